/* hw/rtl/gregorian_date_difference_core_assert.svh */
// Assertion macros for the date difference core.
// Expects i_clk and i_rst_n in the including scope; no other dependencies.
`ifndef GREGORIAN_DATE_DIFFERENCE_CORE_ASSERT_SVH
`define GREGORIAN_DATE_DIFFERENCE_CORE_ASSERT_SVH

// same-cycle implication, checked outside reset
`define GDD_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define GDD_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gdd_pkg.sv */
// Types, constants, tables and microprogram of the date difference core.
// No dependencies; used by the channel interfaces and the core.
package gdd_pkg;

    typedef struct packed {
        logic [4:0]  start_day;
        logic [3:0]  start_month;
        logic [13:0] start_year;
        logic [4:0]  end_day;
        logic [3:0]  end_month;
        logic [13:0] end_year;
    } t_in_word;

    typedef struct packed {
        logic signed [22:0] day_difference;
        logic [1:0]         date_order;
        logic               status;
    } t_out_word;

    localparam logic [1:0] ORDER_EQUAL   = 2'd0;
    localparam logic [1:0] ORDER_LATER   = 2'd1;
    localparam logic [1:0] ORDER_EARLIER = 2'd2;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

    localparam int ACC_W  = 25;
    localparam int TERM_W = 23;

    localparam logic signed [ACC_W-1:0] DIFF_MAX = 25'sd4194303;
    localparam logic signed [ACC_W-1:0] DIFF_MIN = -25'sd4194304;

    // floor(y / 100) = (y * 5243) >> 19, exact for y below 43690
    localparam logic [12:0] RECIP100   = 13'd5243;
    localparam int          RECIP_SHFT = 19;

    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    localparam logic [3:0] MONTH_JAN = 4'd1;
    localparam logic [3:0] MONTH_FEB = 4'd2;
    localparam logic [3:0] MONTH_DEC = 4'd12;

    typedef logic [4:0] t_step;

    typedef enum logic [2:0] {
        SRC_NONE,
        SRC_PROD,
        SRC_CEIL4,
        SRC_CEIL100,
        SRC_CEIL400,
        SRC_MDAY
    } t_src;

    typedef struct packed {
        logic  sel_end;
        logic  do_quo;
        logic  do_rem;
        logic  do_chk;
        logic  do_mul;
        t_src  src;
        logic  neg;
        logic  jmp_bad;
        t_step tgt;
        logic  fin;
    } t_uword;

    localparam t_uword UW_NOP = '0;

    localparam t_step S_QUO    = 5'd0;
    localparam t_step S_REM    = 5'd1;
    localparam t_step S_CHK    = 5'd2;
    localparam t_step S_PROD   = 5'd3;
    localparam t_step S_C4     = 5'd4;
    localparam t_step S_C100   = 5'd5;
    localparam t_step S_C400   = 5'd6;
    localparam t_step S_MDAY   = 5'd7;
    localparam t_step E_QUO    = 5'd8;
    localparam t_step E_REM    = 5'd9;
    localparam t_step E_CHK    = 5'd10;
    localparam t_step E_PROD   = 5'd11;
    localparam t_step E_C4     = 5'd12;
    localparam t_step E_C100   = 5'd13;
    localparam t_step E_C400   = 5'd14;
    localparam t_step E_MDAY   = 5'd15;
    localparam t_step STEP_FIN = 5'd16;

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    function automatic logic [4:0] month_length(input logic [3:0] m, input logic leap);
        logic [4:0] n;
        unique case (m)
            4'd2:                                   n = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:                n = 5'd30;
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10,
            4'd12:                                  n = 5'd31;
            default:                                n = 5'd0;
        endcase
        return n;
    endfunction

    // Start date is subtracted, end date added; the century term flips sign.
    function automatic t_uword ucode(input t_step step);
        t_uword w;
        w         = UW_NOP;
        w.sel_end = (step >= E_QUO);
        unique case (step)
            S_QUO, E_QUO: w.do_quo = 1'b1;
            S_REM, E_REM: w.do_rem = 1'b1;
            S_CHK, E_CHK: begin
                w.do_chk = 1'b1;
                w.do_mul = 1'b1;
            end
            S_PROD, E_PROD: begin
                w.src     = SRC_PROD;
                w.neg     = (step == S_PROD);
                w.jmp_bad = 1'b1;
                w.tgt     = E_MDAY;
            end
            S_C4, E_C4: begin
                w.src = SRC_CEIL4;
                w.neg = (step == S_C4);
            end
            S_C100, E_C100: begin
                w.src = SRC_CEIL100;
                w.neg = (step == E_C100);
            end
            S_C400, E_C400: begin
                w.src = SRC_CEIL400;
                w.neg = (step == S_C400);
            end
            S_MDAY, E_MDAY: begin
                w.src = SRC_MDAY;
                w.neg = (step == S_MDAY);
            end
            STEP_FIN: w.fin = 1'b1;
            default:  w = UW_NOP;
        endcase
        return w;
    endfunction

endpackage

/* hw/rtl/gdd_if.sv */
// Valid/ready channels of the date difference core: date pair in, result out.
// Depends on gdd_pkg for the word types.
interface gdd_in_if import gdd_pkg::*; ();
    logic     valid;
    logic     ready;
    t_in_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface gdd_out_if import gdd_pkg::*; ();
    logic      valid;
    logic      ready;
    t_out_word data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* hw/rtl/gregorian_date_difference_core.sv */
// Each accepted date pair runs through the 17-step microprogram on the shared
// year/month datapath, one date pair at a time; an invalid start or end date branches
// early to the last term. A full output register holds the last step. A new date pair
// is taken while the previous result waits.
// Reset (synchronous, active low) returns the sequencer to idle and empties the output.
module gregorian_date_difference_core import gdd_pkg::*; #(
    parameter int MAX_YEAR = 9999
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    gdd_in_if.sink     i_in,
    gdd_out_if.source  o_out
);

    `include "gregorian_date_difference_core_assert.svh"

    logic                    r_busy;
    t_step                   r_step;
    t_in_word                r_dates;
    logic [7:0]              r_q;
    logic [8:0]              r_c100;
    logic                    r_leap;
    logic                    r_bad;
    logic [TERM_W-1:0]       r_prod;
    logic signed [ACC_W-1:0] r_acc;
    logic                    r_out_valid;
    t_out_word               r_out;

    t_uword                  uw;
    logic [13:0]             y_sel;
    logic [3:0]              m_sel;
    logic [4:0]              d_sel;
    logic [26:0]             quo_prod;
    logic [13:0]             hundreds;
    logic                    rem_nz;
    logic                    date_ok;
    logic [14:0]             y_plus3;
    logic [9:0]              c100_plus3;
    logic [8:0]              mday;
    logic [TERM_W-1:0]       term;
    logic signed [ACC_W-1:0] n_acc;
    t_step                   n_step;
    logic                    in_take;
    logic                    out_free;
    t_out_word               n_out;

    assign uw       = ucode(r_step);
    assign in_take  = i_in.valid && !r_busy;
    assign out_free = !r_out_valid || o_out.ready;

    assign i_in.ready  = !r_busy;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    assign y_sel = uw.sel_end ? r_dates.end_year  : r_dates.start_year;
    assign m_sel = uw.sel_end ? r_dates.end_month : r_dates.start_month;
    assign d_sel = uw.sel_end ? r_dates.end_day   : r_dates.start_day;

    assign quo_prod = 27'(y_sel) * 27'(RECIP100);
    assign hundreds = 14'(14'(r_q) * 14'd100);
    assign rem_nz   = (y_sel != hundreds);

    assign date_ok = (17'(y_sel) <= 17'(MAX_YEAR))
                  && (m_sel >= MONTH_JAN) && (m_sel <= MONTH_DEC)
                  && (d_sel != 5'd0) && (d_sel <= month_length(m_sel, r_leap));

    assign y_plus3    = 15'(y_sel) + 15'd3;
    assign c100_plus3 = 10'(r_c100) + 10'd3;
    assign mday       = days_before_month(m_sel)
                      + 9'((m_sel > MONTH_FEB) && r_leap) + 9'(d_sel);

    always_comb begin
        unique case (uw.src)
            SRC_PROD:    term = r_prod;
            SRC_CEIL4:   term = TERM_W'(y_plus3[14:2]);
            SRC_CEIL100: term = TERM_W'(r_c100);
            SRC_CEIL400: term = TERM_W'(c100_plus3[9:2]);
            SRC_MDAY:    term = TERM_W'(mday);
            default:     term = '0;
        endcase
        n_acc = uw.neg ? r_acc - $signed({2'b00, term})
                       : r_acc + $signed({2'b00, term});
    end

    // advance, or take the branch to the last term when a date is invalid
    always_comb begin
        if (uw.jmp_bad && r_bad) begin
            n_step = uw.tgt;
        end else begin
            n_step = r_step + 5'd1;
        end
    end

    always_comb begin
        n_out.status = r_bad ? STATUS_INVALID : STATUS_OK;
        if (r_bad) begin
            n_out.day_difference = '0;
            n_out.date_order     = ORDER_EQUAL;
        end else begin
            priority if (r_acc > DIFF_MAX) begin
                n_out.day_difference = DIFF_MAX[22:0];
            end else if (r_acc < DIFF_MIN) begin
                n_out.day_difference = DIFF_MIN[22:0];
            end else begin
                n_out.day_difference = r_acc[22:0];
            end
            priority if (r_acc == '0) begin
                n_out.date_order = ORDER_EQUAL;
            end else if (r_acc < 0) begin
                n_out.date_order = ORDER_LATER;
            end else begin
                n_out.date_order = ORDER_EARLIER;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_step      <= S_QUO;
            r_out_valid <= 1'b0;
        end else begin
            if (r_busy && uw.fin && out_free) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (!r_busy) begin
                if (in_take) begin
                    r_busy <= 1'b1;
                    r_step <= S_QUO;
                end
            end else if (uw.fin) begin
                // hold in the last step until the output register frees up
                if (out_free) begin
                    r_busy <= 1'b0;
                end
            end else begin
                r_step <= n_step;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_dates <= i_in.data;
            r_acc   <= '0;
            r_bad   <= 1'b0;
        end else if (r_busy) begin
            if (uw.do_quo) begin
                r_q <= quo_prod[RECIP_SHFT +: 8];
            end
            if (uw.do_rem) begin
                r_c100 <= 9'(r_q) + 9'(rem_nz);
                r_leap <= (y_sel[1:0] == 2'b00) && (rem_nz || (r_q[1:0] == 2'b00));
            end
            if (uw.do_chk) begin
                r_bad <= r_bad || !date_ok;
            end
            if (uw.do_mul) begin
                r_prod <= TERM_W'(TERM_W'(y_sel) * TERM_W'(DAYS_PER_YEAR));
            end
            if (uw.src != SRC_NONE) begin
                r_acc <= n_acc;
            end
        end
        if (r_busy && uw.fin && out_free) begin
            r_out <= n_out;
        end
    end

    `GDD_ASSERT_NXT(a_accept_starts, i_in.valid && i_in.ready,
        r_busy && r_step == S_QUO, "sequencer did not start on accept")
    `GDD_ASSERT_NOW(a_step_range, r_busy, r_step <= STEP_FIN,
        "step counter ran past the program")
    `GDD_ASSERT_NOW(a_invalid_zero, o_out.valid && o_out.data.status == STATUS_INVALID,
        o_out.data.day_difference == '0 && o_out.data.date_order == ORDER_EQUAL,
        "invalid result not zeroed")
    `GDD_ASSERT_NOW(a_order_sign, o_out.valid && o_out.data.status == STATUS_OK,
        (o_out.data.date_order == ORDER_EQUAL) == (o_out.data.day_difference == '0),
        "order disagrees with difference")

endmodule
